### hdl/pld_pkg.sv
// ----------------------------------------------------------------------------
// pld_pkg: shared types and constants of the pkt-line sideband demultiplexer
// Field widths, status codes, stream packing layout and register map.
// ----------------------------------------------------------------------------
package pld_pkg;

  localparam int unsigned DATA_W        = 8;
  localparam int unsigned STATUS_W      = 3;
  localparam int unsigned SHOWN_W       = 32;
  localparam int unsigned COUNT_BITS_DEF = 32;
  localparam int unsigned LEN_W         = 16;

  // Output stream: payload_byte, assembled_count, parse_status, zero fill.
  localparam int unsigned M_TDATA_W     = 48;
  localparam int unsigned M_USED_W      = DATA_W + SHOWN_W + STATUS_W;

  localparam int unsigned APB_ADDR_W    = 3;
  localparam int unsigned APB_DATA_W    = 32;
  localparam logic        REG_BAND_SELECT = 1'b0;
  localparam logic [DATA_W-1:0] BAND_SELECT_RESET = 8'd1;

  localparam logic [STATUS_W-1:0] ST_BUSY   = 3'd0;
  localparam logic [STATUS_W-1:0] ST_FLUSH  = 3'd1;
  localparam logic [STATUS_W-1:0] ST_CLEAN  = 3'd2;
  localparam logic [STATUS_W-1:0] ST_BADHEX = 3'd3;
  localparam logic [STATUS_W-1:0] ST_BADLEN = 3'd4;
  localparam logic [STATUS_W-1:0] ST_TRUNC  = 3'd5;

  typedef struct packed {
    logic [DATA_W-1:0] data_byte;
    logic              first_byte;
    logic              last_byte;
  } item_t;

  typedef struct packed {
    logic                payload_valid;
    logic [DATA_W-1:0]   payload_byte;
    logic [SHOWN_W-1:0]  assembled_count;
    logic [STATUS_W-1:0] parse_status;
  } result_t;

endpackage

### hdl/pld_apb_regs.sv
// ----------------------------------------------------------------------------
// pld_apb_regs: configuration register file
// APB-style port holding the band_select register.
// ----------------------------------------------------------------------------
module pld_apb_regs (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [pld_pkg::APB_ADDR_W-1:0]    paddr,
  input  logic [pld_pkg::APB_DATA_W-1:0]    pwdata,
  output logic [pld_pkg::APB_DATA_W-1:0]    prdata,
  output logic                              pready,
  output logic [pld_pkg::DATA_W-1:0]        band_select_o
);

  logic [pld_pkg::DATA_W-1:0] band_q;
  logic                       wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && (paddr[2] == pld_pkg::REG_BAND_SELECT);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      band_q <= pld_pkg::BAND_SELECT_RESET;
    end else if (wr_en) begin
      band_q <= pwdata[pld_pkg::DATA_W-1:0];
    end
  end

  always_comb begin
    unique case (paddr[2])
      pld_pkg::REG_BAND_SELECT: prdata = pld_pkg::APB_DATA_W'(band_q);
      default:                  prdata = '0;
    endcase
  end

  assign band_select_o = band_q;

endmodule

### hdl/pld_parser.sv
// ----------------------------------------------------------------------------
// pld_parser: pkt-line phase machine
// Holds the parser state and works out the result of one byte in one pass.
// ----------------------------------------------------------------------------
module pld_parser #(
  parameter int unsigned COUNT_BITS = pld_pkg::COUNT_BITS_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic [pld_pkg::DATA_W-1:0] band_select_i,
  input  logic                       step_i,
  input  pld_pkg::item_t             item_i,
  output pld_pkg::result_t           result_o
);

  typedef enum logic [2:0] {
    PH_DIGIT0, PH_DIGIT1, PH_DIGIT2, PH_DIGIT3, PH_BAND, PH_PAYLOAD, PH_STOP
  } phase_e;

  localparam logic [pld_pkg::DATA_W-1:0] CHAR_ZERO = 8'h30;
  localparam logic [pld_pkg::DATA_W-1:0] CHAR_NINE = 8'h39;
  localparam logic [pld_pkg::DATA_W-1:0] CHAR_A    = 8'h61;
  localparam logic [pld_pkg::DATA_W-1:0] CHAR_F    = 8'h66;
  localparam logic [pld_pkg::LEN_W-1:0]  LEN_HDR   = 16'd5;
  localparam logic [3:0]                 HEX_TEN   = 4'd10;

  phase_e                            phase_q, phase_d, phase_cur;
  logic [pld_pkg::LEN_W-1:0]         acc_q, acc_d, acc_cur;
  logic [pld_pkg::LEN_W-1:0]         rem_q, rem_d, rem_cur;
  logic                              match_q, match_d, match_cur;
  logic [COUNT_BITS-1:0]             total_q, total_d, total_cur;
  logic [pld_pkg::STATUS_W-1:0]      status_q, status_d, status_cur;
  logic                              hex_ok;
  logic [3:0]                        digit;
  logic                              valid;
  logic [63:0]                       total_ext;
  logic [pld_pkg::DATA_W-1:0]        b;

  assign b = item_i.data_byte;

  always_comb begin
    hex_ok = 1'b1;
    digit  = '0;
    if (b >= CHAR_ZERO && b <= CHAR_NINE) begin
      digit = 4'(b - CHAR_ZERO);
    end else if (b >= CHAR_A && b <= CHAR_F) begin
      digit = 4'(b - CHAR_A) + HEX_TEN;
    end else begin
      hex_ok = 1'b0;
    end
  end

  always_comb begin
    // A first byte restarts the message before the byte itself is parsed.
    if (item_i.first_byte) begin
      phase_cur  = PH_DIGIT0;
      acc_cur    = '0;
      rem_cur    = '0;
      match_cur  = 1'b0;
      total_cur  = '0;
      status_cur = pld_pkg::ST_BUSY;
    end else begin
      phase_cur  = phase_q;
      acc_cur    = acc_q;
      rem_cur    = rem_q;
      match_cur  = match_q;
      total_cur  = total_q;
      status_cur = status_q;
    end

    phase_d  = phase_cur;
    acc_d    = acc_cur;
    rem_d    = rem_cur;
    match_d  = match_cur;
    total_d  = total_cur;
    status_d = status_cur;
    valid    = 1'b0;

    if (phase_cur != PH_STOP) begin
      unique case (phase_cur)
        PH_DIGIT0, PH_DIGIT1, PH_DIGIT2, PH_DIGIT3: begin
          if (!hex_ok) begin
            status_d = pld_pkg::ST_BADHEX;
            phase_d  = PH_STOP;
          end else begin
            acc_d = {acc_cur[pld_pkg::LEN_W-5:0], digit};
            if (phase_cur == PH_DIGIT3) begin
              if (acc_d == '0) begin
                status_d = pld_pkg::ST_FLUSH;
                phase_d  = PH_STOP;
              end else if (acc_d < LEN_HDR) begin
                status_d = pld_pkg::ST_BADLEN;
                phase_d  = PH_STOP;
              end else begin
                rem_d   = acc_d - LEN_HDR;
                phase_d = PH_BAND;
              end
            end else begin
              phase_d = phase_e'(phase_cur + 3'd1);
            end
          end
        end
        PH_BAND: begin
          match_d = (b == band_select_i);
          acc_d   = '0;
          phase_d = (rem_cur != '0) ? PH_PAYLOAD : PH_DIGIT0;
        end
        default: begin
          if (match_cur) begin
            valid = 1'b1;
            if (total_cur != '1) begin
              total_d = total_cur + 1'b1;
            end
          end
          rem_d = rem_cur - 1'b1;
          if (rem_d == '0) begin
            acc_d   = '0;
            phase_d = PH_DIGIT0;
          end
        end
      endcase

      if (item_i.last_byte && status_d == pld_pkg::ST_BUSY) begin
        status_d = (phase_d == PH_DIGIT0) ? pld_pkg::ST_CLEAN : pld_pkg::ST_TRUNC;
        phase_d  = PH_STOP;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_DIGIT0;
      acc_q    <= '0;
      rem_q    <= '0;
      match_q  <= 1'b0;
      total_q  <= '0;
      status_q <= pld_pkg::ST_BUSY;
    end else if (step_i) begin
      phase_q  <= phase_d;
      acc_q    <= acc_d;
      rem_q    <= rem_d;
      match_q  <= match_d;
      total_q  <= total_d;
      status_q <= status_d;
    end
  end

  // Counts wider than the output field are shown clamped at all ones.
  assign total_ext = 64'(total_d);

  assign result_o.payload_valid   = valid;
  assign result_o.payload_byte    = valid ? b : '0;
  assign result_o.assembled_count = (|total_ext[63:32]) ? '1 : total_ext[31:0];
  assign result_o.parse_status    = status_d;

endmodule

### hdl/pkt_line_sideband_demux_unit.sv
// ----------------------------------------------------------------------------
// pkt_line_sideband_demux_unit: pkt-line sideband demultiplexer
// Parses a pkt-line byte stream and passes the payload of one band.
// ----------------------------------------------------------------------------
// The block takes one stream byte per clock cycle while the output is not
// stalled, and gives one result per byte: a byte lands in the input
// register, the parser stage works it out in a single pass against its
// phase state, and the result waits in the output register. The input side
// keeps accepting while a result is stalled on the output as long as the
// input register can move on. band_select must be written only while the
// stream is idle.
module pkt_line_sideband_demux_unit #(
  parameter int unsigned COUNT_BITS = pld_pkg::COUNT_BITS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // s_axis_tdata: [7:0] data_byte
  input  logic [pld_pkg::DATA_W-1:0]          s_axis_tdata,
  // s_axis_tuser: [0] first_byte
  input  logic                                s_axis_tuser,
  input  logic                                s_axis_tlast,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // m_axis_tdata: [7:0] payload_byte, [39:8] assembled_count,
  // [42:40] parse_status, [47:43] zero
  output logic [pld_pkg::M_TDATA_W-1:0]       m_axis_tdata,
  // m_axis_tuser: [0] payload_valid
  output logic                                m_axis_tuser,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [pld_pkg::APB_ADDR_W-1:0]      paddr,
  input  logic [pld_pkg::APB_DATA_W-1:0]      pwdata,
  output logic [pld_pkg::APB_DATA_W-1:0]      prdata,
  output logic                                pready
);

  logic                       in_vld_q;
  pld_pkg::item_t             in_q;
  logic                       out_vld_q;
  pld_pkg::result_t           out_q;
  pld_pkg::result_t           result;
  logic                       advance;
  logic [pld_pkg::DATA_W-1:0] band_select;

  pld_apb_regs u_regs (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .band_select_o (band_select)
  );

  pld_parser #(
    .COUNT_BITS (COUNT_BITS)
  ) u_parser (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .band_select_i (band_select),
    .step_i        (advance),
    .item_i        (in_q),
    .result_o      (result)
  );

  // The held byte is parsed in the cycle its result can enter the output register.
  assign advance       = in_vld_q && (!out_vld_q || m_axis_tready);
  assign s_axis_tready = !in_vld_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (s_axis_tready) begin
        in_vld_q <= s_axis_tvalid;
      end
      if (!out_vld_q || m_axis_tready) begin
        out_vld_q <= in_vld_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_q.data_byte  <= s_axis_tdata;
      in_q.first_byte <= s_axis_tuser;
      in_q.last_byte  <= s_axis_tlast;
    end
    if (advance) begin
      out_q <= result;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tuser  = out_q.payload_valid;
  assign m_axis_tdata  = {{(pld_pkg::M_TDATA_W - pld_pkg::M_USED_W){1'b0}},
                          out_q.parse_status, out_q.assembled_count, out_q.payload_byte};

endmodule

### hdl/pld_checker.sv
// ----------------------------------------------------------------------------
// pld_checker: port-level checks of the sideband demultiplexer
// Watches the output stream and is bound to the top level.
// ----------------------------------------------------------------------------
module pld_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic [pld_pkg::M_TDATA_W-1:0] m_axis_tdata,
  input logic                          m_axis_tuser,
  input logic                          m_axis_tvalid,
  input logic                          m_axis_tready
);

  logic [pld_pkg::STATUS_W-1:0] status;
  assign status = m_axis_tdata[42:40];

  // A stalled request keeps its payload.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tuser))
    else $error("stalled output request changed");

  // Without a passed byte the byte lane is zero.
  a_zero_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata[7:0] == 8'd0)
    else $error("payload byte set without payload_valid");

  // A passed byte is counted, and only a busy or ending parser passes bytes.
  a_pass_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tdata[39:8] != 32'd0
      && (status == pld_pkg::ST_BUSY || status == pld_pkg::ST_CLEAN
          || status == pld_pkg::ST_TRUNC))
    else $error("passed byte with bad count or status");

  a_status_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> status <= pld_pkg::ST_TRUNC && m_axis_tdata[47:43] == 5'd0)
    else $error("status code out of range or fill bits set");

endmodule

bind pkt_line_sideband_demux_unit pld_checker u_pld_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready)
);

### dv/pkt_line_sideband_demux_unit_tb.sv
// ----------------------------------------------------------------------------
// pkt_line_sideband_demux_unit_tb: self-checking bench of the sideband demux
// Sends pkt-line streams, from a short table and then as random messages,
// predicts every result and compares it with the output stream, with random
// gaps on both sides and band_select changed between traffic phases.
// ----------------------------------------------------------------------------
module pkt_line_sideband_demux_unit_tb;

  localparam int unsigned CYCLE_LIMIT  = 500000;
  localparam int unsigned STREAM_ITEMS = 1550;
  localparam int unsigned N_PHASES     = 5;
  localparam int unsigned N_DIRECTED   = 23;

  typedef enum logic [2:0] {
    LEN_D0, LEN_D1, LEN_D2, LEN_D3, AT_BAND, IN_PAYLOAD, STOPPED
  } line_phase_e;

  typedef struct packed {
    logic [pld_pkg::DATA_W-1:0] data;
    logic                       first;
    logic                       last;
    logic                       typed;
    pld_pkg::result_t           res;
  } dir_row_t;

  logic                           clk_i;
  logic                           rst_ni;
  logic [pld_pkg::DATA_W-1:0]     s_axis_tdata;
  logic                           s_axis_tuser;
  logic                           s_axis_tlast;
  logic                           s_axis_tvalid;
  logic                           s_axis_tready;
  logic [pld_pkg::M_TDATA_W-1:0]  m_axis_tdata;
  logic                           m_axis_tuser;
  logic                           m_axis_tvalid;
  logic                           m_axis_tready;
  logic                           psel;
  logic                           penable;
  logic                           pwrite;
  logic [pld_pkg::APB_ADDR_W-1:0] paddr;
  logic [pld_pkg::APB_DATA_W-1:0] pwdata;
  logic [pld_pkg::APB_DATA_W-1:0] prdata;
  logic                           pready;

  // Shadow of the parser state, kept in step with accepted requests.
  logic [pld_pkg::DATA_W-1:0]   band_sel_q;
  line_phase_e                  phase_q;
  logic [15:0]                  len_acc_q;
  logic [15:0]                  remain_q;
  logic                         band_hit_q;
  logic [pld_pkg::SHOWN_W-1:0]  passed_q;
  logic [pld_pkg::STATUS_W-1:0] status_q;

  pld_pkg::result_t pending_results[$];
  int unsigned      live_items;
  int unsigned      mismatches;
  int unsigned      cycles;
  int unsigned      stall_left;
  bit               idle_on;
  bit               rx_stall_on;

  dir_row_t directed_rows [N_DIRECTED] = '{
    '{"A", 1'b1, 1'b0, 1'b1, '{1'b0, 8'h00, 32'd0, pld_pkg::ST_BADHEX}},
    '{"x", 1'b0, 1'b0, 1'b1, '{1'b0, 8'h00, 32'd0, pld_pkg::ST_BADHEX}},
    '{"0", 1'b1, 1'b0, 1'b1, '{1'b0, 8'h00, 32'd0, pld_pkg::ST_BUSY}},
    '{"0", 1'b0, 1'b0, 1'b0, '0},
    '{"0", 1'b0, 1'b0, 1'b0, '0},
    '{"0", 1'b0, 1'b0, 1'b1, '{1'b0, 8'h00, 32'd0, pld_pkg::ST_FLUSH}},
    '{"0", 1'b1, 1'b0, 1'b0, '0},
    '{"0", 1'b0, 1'b0, 1'b0, '0},
    '{"0", 1'b0, 1'b0, 1'b0, '0},
    '{"4", 1'b0, 1'b0, 1'b1, '{1'b0, 8'h00, 32'd0, pld_pkg::ST_BADLEN}},
    '{"0", 1'b1, 1'b0, 1'b0, '0},
    '{"0", 1'b0, 1'b0, 1'b0, '0},
    '{"0", 1'b0, 1'b0, 1'b0, '0},
    '{"7", 1'b0, 1'b0, 1'b0, '0},
    '{8'h01, 1'b0, 1'b0, 1'b1, '{1'b0, 8'h00, 32'd0, pld_pkg::ST_BUSY}},
    '{8'h00, 1'b0, 1'b0, 1'b1, '{1'b1, 8'h00, 32'd1, pld_pkg::ST_BUSY}},
    '{8'hFF, 1'b0, 1'b1, 1'b1, '{1'b1, 8'hFF, 32'd2, pld_pkg::ST_CLEAN}},
    '{"0", 1'b1, 1'b0, 1'b0, '0},
    '{"0", 1'b0, 1'b0, 1'b0, '0},
    '{"0", 1'b0, 1'b0, 1'b0, '0},
    '{"5", 1'b0, 1'b0, 1'b0, '0},
    '{8'hFF, 1'b0, 1'b1, 1'b1, '{1'b0, 8'h00, 32'd0, pld_pkg::ST_CLEAN}},
    '{"f", 1'b1, 1'b1, 1'b1, '{1'b0, 8'h00, 32'd0, pld_pkg::ST_TRUNC}}
  };

  pkt_line_sideband_demux_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  initial clk_i = 1'b0;
  always #6 clk_i = ~clk_i;

  function automatic logic [4:0] hex_nibble(logic [7:0] b);
    if (b >= "0" && b <= "9") return {1'b0, b[3:0]};
    if (b >= "a" && b <= "f") return 5'(b - "a" + 10);
    return 5'h10;
  endfunction

  function automatic logic [7:0] hex_char(logic [3:0] n);
    return (n < 4'd10) ? 8'(8'h30 + n) : 8'(8'h61 + n - 10);
  endfunction

  function automatic logic [7:0] bad_char();
    logic [7:0] b;
    logic [4:0] nib;
    case ($urandom_range(0, 3))
      0: b = 8'(8'h41 + $urandom_range(0, 6));  // upper case is rejected too
      1: b = "g";
      2: b = $urandom_range(0, 1) ? ":" : "/";
      default: begin
        do begin
          b   = 8'($urandom());
          nib = hex_nibble(b);
        end while (!nib[4]);
      end
    endcase
    return b;
  endfunction

  function automatic pld_pkg::item_t byte_item(logic [7:0] b);
    pld_pkg::item_t it;
    it = '0;
    it.data_byte = b;
    return it;
  endfunction

  function automatic int unsigned next_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 70) return 0;
    if (r < 94) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic void clear_parser();
    phase_q    = LEN_D0;
    len_acc_q  = '0;
    remain_q   = '0;
    band_hit_q = 1'b0;
    passed_q   = '0;
    status_q   = pld_pkg::ST_BUSY;
  endfunction

  // Works out the result of one stream byte and advances the shadow state.
  function automatic pld_pkg::result_t demux_predict(pld_pkg::item_t it);
    pld_pkg::result_t r;
    logic [4:0]       nib;
    r = '0;
    if (it.first_byte) clear_parser();
    if (phase_q != STOPPED) begin
      if (phase_q <= LEN_D3) begin
        nib = hex_nibble(it.data_byte);
        if (nib[4]) begin
          status_q = pld_pkg::ST_BADHEX;
          phase_q  = STOPPED;
        end else begin
          len_acc_q = {len_acc_q[11:0], nib[3:0]};
          if (phase_q == LEN_D3) begin
            if (len_acc_q == 16'd0) begin
              status_q = pld_pkg::ST_FLUSH;
              phase_q  = STOPPED;
            end else if (len_acc_q < 16'd5) begin
              status_q = pld_pkg::ST_BADLEN;
              phase_q  = STOPPED;
            end else begin
              remain_q = len_acc_q - 16'd5;
              phase_q  = AT_BAND;
            end
          end else begin
            phase_q = line_phase_e'(phase_q + 3'd1);
          end
        end
      end else if (phase_q == AT_BAND) begin
        band_hit_q = (it.data_byte == band_sel_q);
        len_acc_q  = '0;
        phase_q    = (remain_q != 16'd0) ? IN_PAYLOAD : LEN_D0;
      end else begin
        if (band_hit_q) begin
          r.payload_valid = 1'b1;
          r.payload_byte  = it.data_byte;
          if (passed_q != '1) passed_q++;
        end
        remain_q--;
        if (remain_q == 16'd0) begin
          len_acc_q = '0;
          phase_q   = LEN_D0;
        end
      end
      if (it.last_byte && status_q == pld_pkg::ST_BUSY) begin
        status_q = (phase_q == LEN_D0) ? pld_pkg::ST_CLEAN : pld_pkg::ST_TRUNC;
        phase_q  = STOPPED;
      end
    end
    r.assembled_count = passed_q;
    r.parse_status    = status_q;
    return r;
  endfunction

  task automatic send_byte(input pld_pkg::item_t it, input bit typed,
                           input pld_pkg::result_t typed_res);
    int unsigned      gap;
    bit               live;
    pld_pkg::result_t r;
    gap = idle_on ? next_gap() : 0;
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= it.data_byte;
    s_axis_tuser  <= it.first_byte;
    s_axis_tlast  <= it.last_byte;
    do @(posedge clk_i); while (!s_axis_tready);
    live = it.first_byte || (phase_q != STOPPED);
    r    = demux_predict(it);
    pending_results.push_back(typed ? typed_res : r);
    if (live) live_items++;
  endtask

  // Holds the sender back until every request has produced its result.
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (pending_results.size() != 0);
  endtask

  task automatic settle();
    drain_results();
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_band(input logic [pld_pkg::DATA_W-1:0] band);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {pld_pkg::REG_BAND_SELECT, 2'b00};
    pwdata  <= {24'($urandom()), band};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    band_sel_q = band;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic run_noise();
    pld_pkg::item_t it;
    int unsigned    n;
    n = $urandom_range(1, 8);
    repeat (n) begin
      it            = byte_item(8'($urandom()));
      it.first_byte = ($urandom_range(0, 7) == 0);
      it.last_byte  = ($urandom_range(0, 7) == 0);
      send_byte(it, 1'b0, '0);
    end
  endtask

  // One message: a few lines, then a flush, a clean or truncated end, or an
  // open end that the next message cuts off.
  task automatic run_message();
    pld_pkg::item_t msg[$];
    pld_pkg::item_t it;
    int unsigned    nlines, kind, lenv, plen, cut, ln, d, n;
    bit             long_line;
    long_line = 1'b0;
    nlines    = $urandom_range(0, 4);
    for (ln = 0; ln < nlines && !long_line; ln++) begin
      kind = $urandom_range(0, 99);
      if (kind < 4) lenv = $urandom_range(1, 4);
      else if (kind < 10) begin
        // A long line is cut short after a few bytes, by the end of input or by the next message.
        lenv      = $urandom_range(5, 16'hFFFF);
        long_line = 1'b1;
      end else if (kind < 85) lenv = 5 + $urandom_range(0, 12);
      else lenv = 5 + $urandom_range(13, 60);
      for (d = 0; d < 4; d++) msg.push_back(byte_item(hex_char(lenv[4*(3-d) +: 4])));
      if ($urandom_range(0, 19) == 0)
        msg[msg.size() - 1 - $urandom_range(0, 3)].data_byte = bad_char();
      if (kind < 4) break;
      case ($urandom_range(0, 9))
        0: msg.push_back(byte_item(8'h00));
        1: msg.push_back(byte_item(8'hFF));
        2, 3: msg.push_back(byte_item(8'($urandom())));
        default: msg.push_back(byte_item(band_sel_q));
      endcase
      plen = long_line ? $urandom_range(0, 6) : lenv - 5;
      repeat (plen) msg.push_back(byte_item(8'($urandom())));
    end
    kind = $urandom_range(0, 99);
    if (long_line) begin
      if (kind < 70) msg[msg.size() - 1].last_byte = 1'b1;
    end else if (kind < 40 || msg.size() == 0) begin
      repeat (4) msg.push_back(byte_item("0"));
      if ($urandom_range(0, 3) == 0) msg[msg.size() - 1].last_byte = 1'b1;
      if ($urandom_range(0, 2) == 0) begin
        n = $urandom_range(1, 3);
        repeat (n) begin
          it           = byte_item(8'($urandom()));
          it.last_byte = 1'($urandom_range(0, 1));
          msg.push_back(it);
        end
      end
    end else if (kind < 65) begin
      msg[msg.size() - 1].last_byte = 1'b1;
    end else begin
      cut = $urandom_range(0, msg.size() - 1);
      msg = msg[0:cut];
      if (kind < 85) msg[msg.size() - 1].last_byte = 1'b1;
    end
    msg[0].first_byte = 1'b1;
    foreach (msg[i]) send_byte(msg[i], 1'b0, '0);
  endtask

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left--;
      m_axis_tready <= 1'b0;
    end else if (rx_stall_on && $urandom_range(0, 2) == 0) begin
      stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40) : $urandom_range(0, 2);
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    pld_pkg::result_t got, want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.payload_valid   = m_axis_tuser;
      got.payload_byte    = m_axis_tdata[pld_pkg::DATA_W-1:0];
      got.assembled_count = m_axis_tdata[pld_pkg::DATA_W +: pld_pkg::SHOWN_W];
      got.parse_status    =
        m_axis_tdata[pld_pkg::DATA_W + pld_pkg::SHOWN_W +: pld_pkg::STATUS_W];
      if (pending_results.size() == 0) begin
        $error("result with no request outstanding: tdata %0h", m_axis_tdata);
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        if (got.payload_valid !== want.payload_valid) begin
          $error("payload_valid: expected %0h, got %0h", want.payload_valid, got.payload_valid);
          mismatches++;
        end
        if (got.payload_byte !== want.payload_byte) begin
          $error("payload_byte: expected %0h, got %0h", want.payload_byte, got.payload_byte);
          mismatches++;
        end
        if (got.assembled_count !== want.assembled_count) begin
          $error("assembled_count: expected %0h, got %0h",
                 want.assembled_count, got.assembled_count);
          mismatches++;
        end
        if (got.parse_status !== want.parse_status) begin
          $error("parse_status: expected %0h, got %0h", want.parse_status, got.parse_status);
          mismatches++;
        end
      end
    end
  end

  initial begin
    logic [pld_pkg::DATA_W-1:0] band_plan [N_PHASES];
    int unsigned                target;
    pld_pkg::item_t             it;
    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= 1'b0;
    s_axis_tlast  <= 1'b0;
    psel          <= 1'b0;
    penable       <= 1'b0;
    pwrite        <= 1'b0;
    paddr         <= '0;
    pwdata        <= '0;
    band_sel_q = pld_pkg::BAND_SELECT_RESET;
    clear_parser();
    idle_on     = 1'b1;
    rx_stall_on = 1'b1;
    band_plan   = '{pld_pkg::BAND_SELECT_RESET, 8'h00, 8'hFF,
                    8'($urandom()), 8'($urandom())};
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i]) begin
      it            = byte_item(directed_rows[i].data);
      it.first_byte = directed_rows[i].first;
      it.last_byte  = directed_rows[i].last;
      send_byte(it, directed_rows[i].typed, directed_rows[i].res);
    end

    for (int p = 0; p < N_PHASES; p++) begin
      if (p != 0) begin
        settle();
        write_band(band_plan[p]);
      end
      target = N_DIRECTED + (STREAM_ITEMS - N_DIRECTED) * (p + 1) / N_PHASES;
      while (live_items < target) begin
        idle_on     = ($urandom_range(0, 3) != 0);
        rx_stall_on = ($urandom_range(0, 3) != 0);
        if ($urandom_range(0, 9) == 0) run_noise();
        else run_message();
        if ($urandom_range(0, 49) == 0) drain_results();
      end
    end

    settle();
    repeat (8) @(posedge clk_i);
    if (mismatches == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

endmodule
